FILE: hdl/assert_macros.svh
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at each rising edge of clk, skipped while rst is high.
`define KMP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop at each rising edge of clk, reset included.
`define KMP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/kmp_pkg.sv
package kmp_pkg;

   localparam int PROFIT_W       = 32;
   localparam int PRICE_W        = 16;
   localparam int TRADES_W       = 7;
   localparam int DEF_MAX_TRADES = 64;
   localparam int GROUP_SIZE     = 16;
   localparam int TRADES_RESET   = 1;

   typedef logic [PROFIT_W-1:0] profit_type;
   typedef logic [PRICE_W-1:0]  price_type;
   typedef logic [TRADES_W-1:0] trades_type;

   typedef struct packed {
      logic      step;
      logic      clear;
      price_type price;
   } cell_ctl_type;

endpackage

FILE: hdl/k_transaction_max_profit_dp.sv
// Best profit from at most max_trades buy-sell transactions over a price run.
// Request channel (req_valid / req_stall): one price per transfer, last day
// first; req_last_day marks the earliest day and closes the run.
// Response channel (rsp_valid / rsp_stall): one result per request, in order,
// rsp_best_profit is the best profit over the days seen so far, saturated at
// 32 bits; rsp_final_result marks the answer for the whole run.
// Configuration (csr_valid / csr_ready): writes max_trades; csr_ready is
// always high. Write it only while no request is in flight.
// From request transfer to response valid a request passes the row of cells
// (one cell per transaction count, all updating from the old values of their
// neighbors), the group OR register of the selected cell and the response
// register. Throughput is one request per cycle unless a response is stalled.
// When the response waits under rsp_stall the whole pipeline holds and
// req_stall is raised in the same cycle.
// Reset clears all cell profits and the pipeline valid flags, and sets max_trades to 1.
// After the request marked last day the cells clear for the next run.
module k_transaction_max_profit_dp #(
   parameter int MAX_TRADES = kmp_pkg::DEF_MAX_TRADES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  kmp_pkg::price_type  req_price,
   input  logic                req_last_day,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kmp_pkg::profit_type rsp_best_profit,
   output logic                rsp_final_result,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  kmp_pkg::trades_type csr_max_trades
);
   import kmp_pkg::*;

   localparam int CNT_W = $clog2(MAX_TRADES + 1);

   trades_type       max_trades_ff;
   logic [CNT_W-1:0] limit;
   logic             adv;
   logic             accept;
   cell_ctl_type     ctl;
   logic             sel [MAX_TRADES];
   profit_type       free_vals [MAX_TRADES];
   profit_type       picks [MAX_TRADES];
   profit_type       reduced;

   logic             v1_ff, v2_ff;
   logic             f1_ff, f2_ff;
   logic             rsp_valid_ff;
   logic             rsp_final_ff;
   profit_type       rsp_best_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_trades_ff <= TRADES_W'(TRADES_RESET);
      end else if (csr_valid && csr_ready) begin
         max_trades_ff <= csr_max_trades;
      end
   end

   always_comb begin
      if (32'(max_trades_ff) > MAX_TRADES) begin
         limit = CNT_W'(MAX_TRADES);
      end else begin
         limit = CNT_W'(max_trades_ff);
      end
   end

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   assign ctl.step  = accept;
   assign ctl.clear = req_last_day;
   assign ctl.price = req_price;

   for (genvar i = 0; i < MAX_TRADES; i++) begin : g_cell
      assign sel[i] = (limit == CNT_W'(i + 1));
      if (i == 0) begin : g_first
         kmp_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .sel       (sel[i]),
            .prev_free ('0),
            .free_out  (free_vals[i]),
            .pick_out  (picks[i])
         );
      end else begin : g_next
         kmp_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .sel       (sel[i]),
            .prev_free (free_vals[i-1]),
            .free_out  (free_vals[i]),
            .pick_out  (picks[i])
         );
      end
   end

   kmp_reduce #(
      .CELLS (MAX_TRADES)
   ) u_reduce (
      .clock  (clock),
      .en     (adv),
      .picks  (picks),
      .result (reduced)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff        <= req_last_day;
         f2_ff        <= f1_ff;
         rsp_final_ff <= f2_ff;
         rsp_best_ff  <= reduced;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_profit  = rsp_best_ff;
   assign rsp_final_result = rsp_final_ff;

endmodule

FILE: hdl/kmp_cell.sv
module kmp_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  kmp_pkg::cell_ctl_type ctl,
   input  logic                 sel,
   input  kmp_pkg::profit_type  prev_free,
   output kmp_pkg::profit_type  free_out,
   output kmp_pkg::profit_type  pick_out
);
   import kmp_pkg::*;

   profit_type       free_ff, free_in;
   profit_type       hold_ff, hold_in;
   profit_type       pick_ff, pick_in;
   profit_type       price_ext;
   profit_type       sell_val;
   profit_type       buy_val;
   logic [PROFIT_W:0] buy_sum;

   always_comb begin
      price_ext = {{(PROFIT_W-PRICE_W){1'b0}}, ctl.price};
      sell_val  = hold_ff - price_ext;
      if (hold_ff >= price_ext && sell_val > free_ff) begin
         free_in = sell_val;
      end else begin
         free_in = free_ff;
      end
      buy_sum = {1'b0, price_ext} + {1'b0, prev_free};
      buy_val = buy_sum[PROFIT_W] ? '1 : buy_sum[PROFIT_W-1:0];
      hold_in = (hold_ff > buy_val) ? hold_ff : buy_val;
      pick_in = sel ? free_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
         hold_ff <= '0;
      end else if (ctl.step) begin
         if (ctl.clear) begin
            free_ff <= '0;
            hold_ff <= '0;
         end else begin
            free_ff <= free_in;
            hold_ff <= hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         pick_ff <= pick_in;
      end
   end

   assign free_out = free_ff;
   assign pick_out = pick_ff;

endmodule

FILE: hdl/kmp_reduce.sv
module kmp_reduce #(
   parameter int CELLS = kmp_pkg::DEF_MAX_TRADES
) (
   input  logic                clock,
   input  logic                en,
   input  kmp_pkg::profit_type picks [CELLS],
   output kmp_pkg::profit_type result
);
   import kmp_pkg::*;

   localparam int GROUPS = (CELLS + GROUP_SIZE - 1) / GROUP_SIZE;

   profit_type group_ff [GROUPS];
   profit_type group_in [GROUPS];

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < CELLS) begin
               group_in[g] = group_in[g] | picks[g * GROUP_SIZE + j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         group_ff <= group_in;
      end
   end

   always_comb begin
      result = '0;
      for (int g = 0; g < GROUPS; g++) begin
         result = result | group_ff[g];
      end
   end

endmodule

FILE: hdl/kmp_checker.sv
`include "assert_macros.svh"

module kmp_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input kmp_pkg::price_type  req_price,
   input logic                req_last_day,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input kmp_pkg::profit_type rsp_best_profit,
   input logic                rsp_final_result,
   input logic                csr_valid,
   input logic                csr_ready
);

   `KMP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_best_profit) && $stable(rsp_final_result), "stalled response changed")

   `KMP_ASSERT(a_req_hold, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_price) && $stable(req_last_day), "stalled request changed")

   `KMP_ASSERT(a_req_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "request stalled without a waiting response")

   `KMP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "response valid after reset")

   `KMP_ASSERT(a_csr_ready, clock, reset, csr_valid |-> csr_ready, "configuration write refused")

endmodule

bind k_transaction_max_profit_dp kmp_checker u_kmp_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import kmp_pkg::*;

   localparam int TRADES      = DEF_MAX_TRADES;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      price_type price;
      logic      last_day;
   } day_t;

   typedef struct {
      profit_type best_profit;
      logic       final_result;
   } answer_t;

   typedef enum {
      PRICE_FULL,
      PRICE_NARROW,
      PRICE_EXTREME,
      PRICE_RAMP
   } price_style_t;

   typedef enum {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_t;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   price_type  req_price      = '0;
   logic       req_last_day   = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   profit_type rsp_best_profit;
   logic       rsp_final_result;
   logic       csr_valid      = 1'b0;
   logic       csr_ready;
   trades_type csr_max_trades = '0;

   day_t        days_pending[$];
   answer_t     answers_due[$];
   profit_type  free_tab[TRADES];
   profit_type  hold_tab[TRADES];
   trades_type  trade_limit = trades_type'(TRADES_RESET);
   logic        req_fire    = 1'b0;
   int unsigned req_count   = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;
   int unsigned gap_left    = 0;
   int unsigned hold_left   = 0;
   int unsigned mode_left   = 0;
   logic        held_once   = 1'b0;
   stall_mode_t stall_mode  = STALL_NONE;

   k_transaction_max_profit_dp #(
      .MAX_TRADES(TRADES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_price       (req_price),
      .req_last_day    (req_last_day),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_best_profit (rsp_best_profit),
      .rsp_final_result(rsp_final_result),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_trades  (csr_max_trades)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic answer_t price_step(input price_type price, input logic last_day);
      profit_type        lower_free;
      profit_type        old_free;
      profit_type        old_hold;
      profit_type        new_free;
      profit_type        new_hold;
      logic [PROFIT_W:0] sum;
      int unsigned       k;
      answer_t           a;
      lower_free = '0;
      for (int t = 0; t < TRADES; t++) begin
         old_free = free_tab[t];
         old_hold = hold_tab[t];
         new_free = old_free;
         if (old_hold >= profit_type'(price) && old_hold - profit_type'(price) > old_free)
            new_free = old_hold - profit_type'(price);
         sum = {1'b0, lower_free} + (PROFIT_W+1)'(price);
         new_hold = sum[PROFIT_W] ? '1 : sum[PROFIT_W-1:0];
         if (old_hold > new_hold)
            new_hold = old_hold;
         free_tab[t] = new_free;
         hold_tab[t] = new_hold;
         lower_free  = old_free;
      end
      k = (trade_limit > TRADES) ? TRADES : trade_limit;
      a.best_profit  = (k == 0) ? '0 : free_tab[k-1];
      a.final_result = last_day;
      if (last_day) begin
         for (int t = 0; t < TRADES; t++) begin
            free_tab[t] = '0;
            hold_tab[t] = '0;
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      answer_t due;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("response without pending request: best_profit %0d final_result %0d",
                      rsp_best_profit, rsp_final_result);
               error_count++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_best_profit !== due.best_profit) begin
                  $error("best_profit expected %0d actual %0d", due.best_profit,
                         rsp_best_profit);
                  error_count++;
               end
               if (rsp_final_result !== due.final_result) begin
                  $error("final_result expected %0d actual %0d", due.final_result,
                         rsp_final_result);
                  error_count++;
               end
            end
         end
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            answers_due.push_back(price_step(req_price, req_last_day));
            req_count <= req_count + 1;
         end
         if (csr_valid && csr_ready)
            trade_limit <= csr_max_trades;
      end
   end

   always @(negedge clock) begin
      logic next_valid;
      logic hold;
      if (req_fire)
         void'(days_pending.pop_front());
      hold       = req_valid && !req_fire;
      next_valid = hold;
      if (!hold && !reset && days_pending.size() != 0) begin
         if (burst_left != 0) begin
            next_valid = 1'b1;
            burst_left--;
         end else if (gap_left != 0) begin
            gap_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
      req_valid <= next_valid;
      if (next_valid && !hold) begin
         req_price    <= days_pending[0].price;
         req_last_day <= days_pending[0].last_day;
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!held_once && req_count >= 250 && days_pending.size() > 30) begin
         held_once = 1'b1;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= cycle_count[1];
         endcase
      end
   end

   function automatic int unsigned pick_price(input price_style_t style, input int unsigned i);
      int unsigned p;
      case (style)
         PRICE_NARROW:  p = $urandom_range(0, 15);
         PRICE_EXTREME: begin
            p = (i % 2) ? 65535 : 0;
            if ($urandom_range(0, 7) == 0)
               p = 65535 - p;
         end
         PRICE_RAMP:    p = (i * 1000 > 65535) ? 65535 : i * 1000;
         default:       p = $urandom_range(0, 65535);
      endcase
      return p;
   endfunction

   task automatic add_day(input int unsigned price, input logic last_day);
      day_t d;
      d.price    = price_type'(price);
      d.last_day = last_day;
      days_pending.push_back(d);
   endtask

   task automatic add_run(input int unsigned len, input price_style_t style, input logic close);
      for (int unsigned i = 0; i < len; i++)
         add_day(pick_price(style, i), close && (i == len - 1));
   endtask

   task automatic write_limit(input int unsigned value);
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_max_trades <= trades_type'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (days_pending.size() != 0 || answers_due.size() != 0 || req_valid)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   initial begin
      int unsigned  limit;
      int unsigned  phase_items;
      int unsigned  target;
      int unsigned  len;
      price_style_t style;
      for (int t = 0; t < TRADES; t++) begin
         free_tab[t] = '0;
         hold_tab[t] = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_day(65535, 1'b1);
      add_day(100, 1'b0);
      add_day(65535, 1'b0);
      add_day(0, 1'b0);
      add_day(65535, 1'b0);
      add_day(0, 1'b1);
      wait_idle();
      write_limit(0);
      add_run(4, PRICE_EXTREME, 1'b1);
      wait_idle();
      write_limit(127);
      add_run(10, PRICE_EXTREME, 1'b1);
      wait_idle();
      write_limit(64);
      add_run(4, PRICE_NARROW, 1'b0);
      wait_idle();
      write_limit(2);
      add_run(3, PRICE_FULL, 1'b1);
      wait_idle();

      for (int ph = 0; ph < 12; ph++) begin
         case ($urandom_range(0, 8))
            0:       limit = 0;
            1:       limit = 1;
            2:       limit = 2;
            3:       limit = 3;
            4:       limit = 63;
            5:       limit = 64;
            6:       limit = 65;
            7:       limit = 127;
            default: limit = $urandom_range(0, 127);
         endcase
         write_limit(limit);
         target      = (ph == 2) ? 150 : 30;
         phase_items = 0;
         while (phase_items < target) begin
            style = price_style_t'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) begin
               len   = $urandom_range(40, 140);
               style = PRICE_EXTREME;
            end else begin
               len = $urandom_range(1, 24);
            end
            add_run(len, style, $urandom_range(0, 7) != 0);
            phase_items += len;
         end
         wait_idle();
      end

      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
